@@ rtl/lkg_pkg.sv @@
package lkg_pkg;

	localparam int DEF_MAX_WIDTH = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DATA_W = 16;
	localparam int CFG_W = 7;
	localparam int DIM_W = 9;
	localparam int OP_W = 3;
	localparam int ACC_W = 36;
	localparam int FRAC_SHIFT = 14;

	localparam logic REG_GRID_WIDTH = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_WR_CELL   = 3'd0,
		OP_WR_WEIGHT = 3'd1,
		OP_WR_BIAS   = 3'd2,
		OP_STEP      = 3'd3,
		OP_STEP_BIAS = 3'd4,
		OP_READ      = 3'd5,
		OP_CLEAR     = 3'd6,
		OP_NOP       = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_STEP,
		ST_DRAIN,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic nb_ok;
		logic use_bias;
	} mac_ctl_t;

	// Clamp a configured grid dimension to 2..maxv.
	function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v, logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] ext;
		ext = DIM_W'(v);
		if (ext < DIM_W'(2))
			return DIM_W'(2);
		else if (ext > maxv)
			return maxv;
		else
			return ext;
	endfunction

endpackage

@@ rtl/local_kernel_grid_step.sv @@
// Locally connected 3x3 stencil over a grid of Q8.8 cells in two ping-pong planes.
// Input channel (in_valid/in_stall) carries one command item; every item yields
// exactly one result item on the output channel (out_valid/out_stall), held in an
// output register until taken. A new item is taken only once the previous result
// has left the output register.
// Cell, weight and bias writes and no-ops answer from the idle state; a cell read
// passes through a read state; a clear sweeps both planes over all cells; a step
// visits every cell of the active W x H grid and then drains the MAC pipeline.
// A step visits one kernel tap per cycle, as the weight memory has a single
// read port.
// After reset the block sweeps both cell planes to zero, one cell a cycle,
// and stalls its input meanwhile; configuration writes are taken at any time.
// Weights and biases are not initialized.
// A stalled receiver holds the result; the input stays stalled until it is taken.
module local_kernel_grid_step #(
	parameter int MAX_WIDTH = lkg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lkg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [lkg_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lkg_pkg::OP_W-1:0]           opcode,
	input  logic [5:0]                         cell_x,
	input  logic [5:0]                         cell_y,
	input  logic [3:0]                         tap_index,
	input  logic signed [lkg_pkg::DATA_W-1:0]  data_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lkg_pkg::DATA_W-1:0]  read_value,
	output logic                               saturated
);
	import lkg_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CW = XW + YW;
	localparam int CELLS = 1 << CW;
	localparam int TAPS = 9 * CELLS;
	localparam int TAW = $clog2(TAPS);

	state_t                   state_q, state_d;
	logic                     done;
	logic [CFG_W-1:0]         gw_q, gh_q;
	logic [DIM_W-1:0]         w_eff, h_eff;
	opcode_t                  op;
	logic                     in_acc, in_range;
	logic [CW-1:0]            item_cell;

	logic [XW-1:0]            cx_q;
	logic [YW-1:0]            cy_q;
	logic [1:0]               tdx_q, tdy_q, drain_q;
	logic [CW-1:0]            clr_q;
	logic                     with_bias_q, rd_ok_q, plane_sel_q, clip_q, clip_nx;
	logic                     last_tap, first_tap, last_cell, nb_ok, sweep;
	logic [3:0]               tap_sel;
	logic [DIM_W:0]           nx, ny;
	logic [CW-1:0]            cur_cell, nb_cell, plane_ra;
	logic [TAW-1:0]           tap_ra, tap_wa;

	logic signed [DATA_W-1:0] plane0 [CELLS];
	logic signed [DATA_W-1:0] plane1 [CELLS];
	logic signed [DATA_W-1:0] taps [TAPS];
	logic signed [DATA_W-1:0] bias [CELLS];
	logic signed [DATA_W-1:0] p0_rd_q, p1_rd_q, tap_rd_q, bias_rd_q, src_rd;

	logic                     we0, we1, wcell;
	logic [CW-1:0]            wa0, wa1;
	logic signed [DATA_W-1:0] wd0, wd1;

	mac_ctl_t                 ctl_s1;
	logic [CW-1:0]            cell_s1, cell_s2, cell_s3;
	logic                     res_valid, res_clip;
	logic signed [DATA_W-1:0] res_value;

	logic                     out_valid_q, sat_q;
	logic signed [DATA_W-1:0] read_value_q;

	assign w_eff = clamp_dim(gw_q, DIM_W'(MAX_WIDTH));
	assign h_eff = clamp_dim(gh_q, DIM_W'(MAX_HEIGHT));
	assign op = opcode_t'(opcode);
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign in_acc = in_valid && !in_stall;
	assign in_range = (DIM_W'(cell_x) < DIM_W'(MAX_WIDTH)) && (DIM_W'(cell_y) < DIM_W'(MAX_HEIGHT));
	assign item_cell = {YW'(cell_y), XW'(cell_x)};

	// step sequencer addressing
	assign cur_cell = {cy_q, cx_q};
	assign tap_sel = {1'b0, tdx_q, 1'b0} + {2'b00, tdx_q} + {2'b00, tdy_q};
	assign nx = (DIM_W+1)'(cx_q) + (DIM_W+1)'(tdx_q) - (DIM_W+1)'(1);
	assign ny = (DIM_W+1)'(cy_q) + (DIM_W+1)'(tdy_q) - (DIM_W+1)'(1);
	assign nb_ok = !nx[DIM_W] && (nx[DIM_W-1:0] < w_eff) && !ny[DIM_W] && (ny[DIM_W-1:0] < h_eff);
	assign nb_cell = {ny[YW-1:0], nx[XW-1:0]};
	assign first_tap = (tdx_q == 2'd0) && (tdy_q == 2'd0);
	assign last_tap = (tdx_q == 2'd2) && (tdy_q == 2'd2);
	assign last_cell = (DIM_W'(cx_q) == w_eff - DIM_W'(1)) && (DIM_W'(cy_q) == h_eff - DIM_W'(1));

	assign plane_ra = (state_q == ST_STEP) ? nb_cell : item_cell;
	assign tap_ra = (TAW'(cur_cell) << 3) + TAW'(cur_cell) + TAW'(tap_sel);
	assign tap_wa = (TAW'(item_cell) << 3) + TAW'(item_cell) + TAW'(tap_index);

	always_comb begin
		state_d = state_q;
		done = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				if (clr_q == '1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					unique case (op) inside
						OP_STEP, OP_STEP_BIAS: state_d = ST_STEP;
						OP_READ: state_d = ST_READ;
						OP_CLEAR: state_d = ST_CLEAR;
						default: done = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
				done = 1'b1;
			end
			ST_STEP: begin
				if (last_tap && last_cell)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q == 2'd2) begin
					state_d = ST_IDLE;
					done = 1'b1;
				end
			end
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
					done = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= CFG_W'(64);
			gh_q <= CFG_W'(64);
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH)
				gw_q <= cfg_data;
			else
				gh_q <= cfg_data;
		end
	end

	assign clip_nx = clip_q || (res_valid && res_clip);
	assign sweep = (state_q == ST_INIT) || (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			tdx_q <= '0;
			tdy_q <= '0;
			drain_q <= '0;
			clr_q <= '0;
			with_bias_q <= 1'b0;
			rd_ok_q <= 1'b0;
			plane_sel_q <= 1'b0;
			clip_q <= 1'b0;
		end else begin
			clip_q <= clip_nx;
			if (sweep)
				clr_q <= clr_q + CW'(1);
			if (state_q == ST_IDLE && in_acc) begin
				cx_q <= '0;
				cy_q <= '0;
				tdx_q <= '0;
				tdy_q <= '0;
				drain_q <= '0;
				with_bias_q <= (op == OP_STEP_BIAS);
				rd_ok_q <= in_range;
				if (op == OP_CLEAR) begin
					plane_sel_q <= 1'b0;
					clip_q <= 1'b0;
				end
			end
			if (state_q == ST_STEP) begin
				if (tdy_q == 2'd2) begin
					tdy_q <= '0;
					if (tdx_q == 2'd2) begin
						tdx_q <= '0;
						if (DIM_W'(cx_q) == w_eff - DIM_W'(1)) begin
							cx_q <= '0;
							cy_q <= cy_q + YW'(1);
						end else begin
							cx_q <= cx_q + XW'(1);
						end
					end else begin
						tdx_q <= tdx_q + 2'd1;
					end
				end else begin
					tdy_q <= tdy_q + 2'd1;
				end
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 2'd1;
				// last result is written at this edge; swap planes with it
				if (drain_q == 2'd2)
					plane_sel_q <= !plane_sel_q;
			end
		end
	end

	// plane write ports: sweep, cell write into current plane, step result into the other
	assign wcell = in_acc && (op == OP_WR_CELL) && in_range;

	always_comb begin
		we0 = sweep || (wcell && !plane_sel_q) || (res_valid && plane_sel_q);
		we1 = sweep || (wcell && plane_sel_q) || (res_valid && !plane_sel_q);
		if (sweep) begin
			wa0 = clr_q;
			wd0 = '0;
			wa1 = clr_q;
			wd1 = '0;
		end else if (res_valid) begin
			wa0 = cell_s3;
			wd0 = res_value;
			wa1 = cell_s3;
			wd1 = res_value;
		end else begin
			wa0 = item_cell;
			wd0 = data_value;
			wa1 = item_cell;
			wd1 = data_value;
		end
	end

	always_ff @(posedge clk) begin
		if (we0)
			plane0[wa0] <= wd0;
		p0_rd_q <= plane0[plane_ra];
	end

	always_ff @(posedge clk) begin
		if (we1)
			plane1[wa1] <= wd1;
		p1_rd_q <= plane1[plane_ra];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_WR_WEIGHT && in_range && tap_index < 4'd9)
			taps[tap_wa] <= data_value;
		tap_rd_q <= taps[tap_ra];
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_WR_BIAS && in_range)
			bias[item_cell] <= data_value;
		bias_rd_q <= bias[cur_cell];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= (state_q == ST_STEP);
			ctl_s1.first <= first_tap;
			ctl_s1.last <= last_tap;
			ctl_s1.nb_ok <= nb_ok;
			ctl_s1.use_bias <= with_bias_q;
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= cur_cell;
		cell_s2 <= cell_s1;
		cell_s3 <= cell_s2;
	end

	assign src_rd = plane_sel_q ? p1_rd_q : p0_rd_q;

	lkg_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_s1),
		.src_value  (src_rd),
		.tap_value  (tap_rd_q),
		.bias_value (bias_rd_q),
		.res_valid  (res_valid),
		.res_value  (res_value),
		.res_clip   (res_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			read_value_q <= (state_q == ST_READ && rd_ok_q) ? src_rd : '0;
			sat_q <= clip_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = read_value_q;
	assign saturated = sat_q;

	a_res_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (state_q == ST_STEP || state_q == ST_DRAIN))
		else $error("step result outside a step");

	a_plane_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(plane_sel_q != $past(plane_sel_q)) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_IDLE))
		else $error("plane select changed outside step end or clear");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> (!out_valid_q && !ctl_s1.valid))
		else $error("activity during initial clear");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && drain_q == 2'd2) |-> (!ctl_s1.valid && res_valid))
		else $error("pipeline not aligned at step end");

endmodule

@@ rtl/lkg_mac.sv @@
module lkg_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lkg_pkg::mac_ctl_t                   ctl,
	input  logic signed [lkg_pkg::DATA_W-1:0]   src_value,
	input  logic signed [lkg_pkg::DATA_W-1:0]   tap_value,
	input  logic signed [lkg_pkg::DATA_W-1:0]   bias_value,
	output logic                                res_valid,
	output logic signed [lkg_pkg::DATA_W-1:0]   res_value,
	output logic                                res_clip
);
	import lkg_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int RND_W = ACC_W - FRAC_SHIFT;

	mac_ctl_t                   ctl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [DATA_W-1:0]   bias_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_sum;
	logic signed [ACC_W-1:0]    bias_term;
	logic signed [ACC_W-1:0]    sum_s3;
	logic                       valid_s3;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [RND_W-1:0]    quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			valid_s3 <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			valid_s3 <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// Neighbors outside the grid contribute zero.
	always_ff @(posedge clk) begin
		prod_s2 <= ctl.nb_ok ? PROD_W'(src_value * tap_value) : '0;
		bias_s2 <= bias_value;
	end

	assign acc_sum = (ctl_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
	assign bias_term = ctl_s2.use_bias ? (ACC_W'(bias_s2) <<< FRAC_SHIFT) : ACC_W'(0);

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= acc_sum;
			if (ctl_s2.last)
				sum_s3 <= acc_sum + bias_term;
		end
	end

	// Round half up to Q8.8, then saturate.
	assign rnd = sum_s3 + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
	assign quot = RND_W'(rnd >>> FRAC_SHIFT);

	always_comb begin
		res_clip = 1'b0;
		res_value = quot[DATA_W-1:0];
		if (quot > RND_W'(32767)) begin
			res_clip = 1'b1;
			res_value = 16'sh7fff;
		end else if (quot < -RND_W'(32768)) begin
			res_clip = 1'b1;
			res_value = 16'sh8000;
		end
	end

	assign res_valid = valid_s3;

endmodule

@@ tb/tb_local_kernel_grid_step.sv @@
module tb_local_kernel_grid_step;
	timeunit 1ns;
	timeprecision 1ps;

	import lkg_pkg::*;

	localparam int GRID_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     clip;
	} grid_result_t;

	class grid_scoreboard;
		logic signed [DATA_W-1:0] plane [2][GRID_CELLS];
		logic signed [DATA_W-1:0] kern [9*GRID_CELLS];
		logic signed [DATA_W-1:0] bias [GRID_CELLS];
		bit kern_set [9*GRID_CELLS];
		bit bias_set [GRID_CELLS];
		bit sel;
		bit clip;
		int cfg_w;
		int cfg_h;
		grid_result_t pending [$];
		int mismatches;
		int n_items;
		int n_steps;
		int n_reads;
		int n_clips;

		function new();
			foreach (plane[p, c]) plane[p][c] = '0;
			cfg_w = DEF_MAX_WIDTH;
			cfg_h = DEF_MAX_HEIGHT;
		endfunction

		function int eff_w();
			return cfg_w < 2 ? 2 : (cfg_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : cfg_w);
		endfunction

		function int eff_h();
			return cfg_h < 2 ? 2 : (cfg_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : cfg_h);
		endfunction

		function void run_stencil(bit with_bias);
			int gw, gh, cidx, nx, ny;
			longint acc, r;
			gw = eff_w();
			gh = eff_h();
			for (int y = 0; y < gh; y++) begin
				for (int x = 0; x < gw; x++) begin
					cidx = y * DEF_MAX_WIDTH + x;
					acc = 0;
					for (int dx = -1; dx <= 1; dx++) begin
						for (int dy = -1; dy <= 1; dy++) begin
							nx = x + dx;
							ny = y + dy;
							if (nx >= 0 && ny >= 0 && nx < gw && ny < gh)
								acc += longint'(plane[sel][ny*DEF_MAX_WIDTH+nx])
									* longint'(kern[cidx*9 + (dx+1)*3 + (dy+1)]);
						end
					end
					if (with_bias)
						acc += longint'(bias[cidx]) <<< FRAC_SHIFT;
					r = (acc + 64'sd8192) >>> FRAC_SHIFT;
					if (r > 32767) begin
						clip = 1;
						r = 32767;
					end else if (r < -32768) begin
						clip = 1;
						r = -32768;
					end
					plane[!sel][cidx] = DATA_W'(r);
				end
			end
			sel = !sel;
		endfunction

		function void note_item(opcode_t op, logic [5:0] x, logic [5:0] y,
			logic [3:0] tap, logic signed [DATA_W-1:0] data);
			int cidx;
			grid_result_t res;
			cidx = int'(y) * DEF_MAX_WIDTH + int'(x);
			res.value = '0;
			n_items++;
			case (op)
				OP_WR_CELL: plane[sel][cidx] = data;
				OP_WR_WEIGHT: begin
					if (tap < 9) begin
						kern[cidx*9 + tap] = data;
						kern_set[cidx*9 + tap] = 1;
					end
				end
				OP_WR_BIAS: begin
					bias[cidx] = data;
					bias_set[cidx] = 1;
				end
				OP_STEP, OP_STEP_BIAS: begin
					run_stencil(op == OP_STEP_BIAS);
					n_steps++;
				end
				OP_READ: begin
					res.value = plane[sel][cidx];
					n_reads++;
				end
				OP_CLEAR: begin
					foreach (plane[p, c]) plane[p][c] = '0;
					sel = 0;
					clip = 0;
				end
				default: ;
			endcase
			res.clip = clip;
			if (clip) n_clips++;
			pending.push_back(res);
		endfunction

		function void check(logic signed [DATA_W-1:0] value, logic sat);
			grid_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_value=%0d saturated=%0b", value, sat);
				return;
			end
			want = pending.pop_front();
			if (value !== want.value || sat !== want.clip) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: read_value exp %0d got %0d, saturated exp %0b got %0b",
						want.value, value, want.clip, sat);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] opcode;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic [3:0] tap_index;
	logic signed [DATA_W-1:0] data_value;
	logic out_valid;
	logic out_stall;
	logic signed [DATA_W-1:0] read_value;
	logic saturated;

	grid_scoreboard sb;
	bit idle_on;
	bit hold_req;
	int quiet_cycles;

	local_kernel_grid_step i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.tap_index  (tap_index),
		.data_value (data_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.saturated  (saturated)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_stall = 0;
		forever begin
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check(read_value, saturated);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(opcode_t op, int x, int y, int tap, int data);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		cell_x <= 6'(x);
		cell_y <= 6'(y);
		tap_index <= 4'(tap);
		data_value <= DATA_W'(data);
		do @(posedge clk); while (in_stall);
		sb.note_item(op, 6'(x), 6'(y), 4'(tap), DATA_W'(data));
	endtask

	// drop valid and hold until the block has answered everything
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		drain();
		cfg_we <= 1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 0;
		sb.cfg_w = int'(w);
		sb.cfg_h = int'(h);
		// a step reads every kernel and bias of the active grid: fill the gaps
		for (int y = 0; y < sb.eff_h(); y++) begin
			for (int x = 0; x < sb.eff_w(); x++) begin
				for (int t = 0; t < 9; t++)
					if (!sb.kern_set[(y*DEF_MAX_WIDTH+x)*9 + t])
						send_item(OP_WR_WEIGHT, x, y, t, $urandom_range(0, 16'hffff) >>> 2);
				if (!sb.bias_set[y*DEF_MAX_WIDTH+x])
					send_item(OP_WR_BIAS, x, y, $urandom_range(0, 15), $urandom);
			end
		end
	endtask

	task automatic random_items(int count);
		int pick;
		int x, y;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 1)) begin
				x = $urandom_range(0, sb.eff_w() - 1);
				y = $urandom_range(0, sb.eff_h() - 1);
			end else begin
				x = $urandom;
				y = $urandom;
			end
			if (pick < 28)
				send_item(OP_WR_CELL, x, y, $urandom, $urandom);
			else if (pick < 52)
				send_item(OP_READ, x, y, $urandom, $urandom);
			else if (pick < 66)
				send_item(OP_STEP, x, y, $urandom, $urandom);
			else if (pick < 76)
				send_item(OP_STEP_BIAS, x, y, $urandom, $urandom);
			else if (pick < 88)
				send_item(OP_WR_WEIGHT, x, y, $urandom, $urandom);
			else if (pick < 94)
				send_item(OP_WR_BIAS, x, y, $urandom, $urandom);
			else if (pick < 97)
				send_item(OP_CLEAR, x, y, $urandom, $urandom);
			else
				send_item(OP_NOP, x, y, $urandom, $urandom);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = '0;
		in_valid = 0;
		opcode = '0;
		cell_x = '0;
		cell_y = '0;
		tap_index = '0;
		data_value = '0;
		quiet_cycles = 0;
		idle_on = 1;
		hold_req = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// out-of-range sizes clamp to the smallest grid
		set_grid(7'd1, 7'd0);
		send_item(OP_WR_CELL, 0, 0, 0, 32767);
		send_item(OP_WR_CELL, 63, 1, 0, -32768);
		send_item(OP_WR_CELL, 5, 63, 15, 256);
		send_item(OP_READ, 5, 63, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0);
		send_item(OP_WR_WEIGHT, 1, 0, 9, 16384);
		send_item(OP_WR_WEIGHT, 1, 0, 15, -16384);
		send_item(OP_WR_WEIGHT, 0, 0, 4, 32767);
		send_item(OP_WR_BIAS, 63, 1, 0, 32767);
		send_item(OP_NOP, 63, 63, 15, -1);
		send_item(OP_STEP, 0, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0);
		send_item(OP_READ, 63, 1, 0, 0);
		send_item(OP_STEP_BIAS, 0, 0, 0, 0);
		send_item(OP_READ, 63, 1, 0, 0);
		send_item(OP_READ, 5, 63, 0, 0);
		send_item(OP_CLEAR, 0, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 0);
		random_items(12);

		// three columns, two rows; long receiver hold that keeps the input stalled
		set_grid(7'd3, 7'd2);
		hold_req = 1;
		random_items(12);

		set_grid(7'd2, 7'd3);
		random_items(12);

		// no idling from here on
		set_grid(7'd2, 7'd2);
		idle_on = 0;
		random_items(12);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d items: %0d steps, %0d reads, %0d results with clip flag set",
			sb.n_items, sb.n_steps, sb.n_reads, sb.n_clips);
		$display("grid sizes 2x2 (clamped), 3x2, 2x3 and 2x2, mismatches %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
